// ===== rtl/sros_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite row opaque span package
// Shared widths, register indexes and reset values for the span finder.
// ----------------------------------------------------------------------------
package sros_pkg;

    localparam int unsigned PIX_W      = 8;   // packed byte width
    localparam int unsigned COORD_W    = 8;   // column, row and size width
    localparam int unsigned LANES      = 4;   // most pixels one byte can hold
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned OUT_DATA_W = 3 * COORD_W;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_BPP_MODE      = 2'd0;
    localparam logic [1:0] REG_SPRITE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SPRITE_HEIGHT = 2'd2;

    localparam logic               BPP_2 = 1'b0;
    localparam logic               BPP_4 = 1'b1;
    localparam logic [COORD_W-1:0] WIDTH_RESET  = 8'd8;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 8'd8;

    localparam logic [1:0] PAIR_MASK   = 2'h3;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

endpackage

// ===== rtl/sprite_row_opaque_span.sv =====
// ----------------------------------------------------------------------------
// Sprite row opaque span finder
// Scans packed sprite bytes row by row and reports, per row, the first
// nonzero column and one past the last nonzero column.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                    | Contents
//  ---------+--------------------------+---------------------------------------
//  input    | s_tvalid/s_tready/s_tdata | one packed pixel byte per request
//  result   | m_tvalid/m_tready/m_tdata | row_index, span_start, span_end
//           | m_tlast                  | last_row of the sprite
//  config   | APB psel/penable/...     | bpp_mode @0, sprite_width @4,
//           |                          | sprite_height @8
//
// One byte is accepted every cycle. A byte is held in the input register,
// where its pixels are evaluated together against the row state; a byte
// that completes a row loads the result register as it leaves the input
// register, so m_tvalid rises once the byte has passed the input register
// and then the result register. The input side stalls only when the held
// byte completes a row while the result register still holds a request
// that is not being taken. Reset (aresetn low, synchronous) empties both
// registers and restores the row state and the register defaults.
// ----------------------------------------------------------------------------
module sprite_row_opaque_span
    import sros_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] row_index, [15:8] span_start,
                                             // [23:16] span_end
    output logic                  m_tlast,   // last_row

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               bpp_mode_reg;
    logic [COORD_W-1:0] sprite_width_reg;
    logic [COORD_W-1:0] sprite_height_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_mode_reg      <= BPP_2;
            sprite_width_reg  <= WIDTH_RESET;
            sprite_height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_BPP_MODE:      bpp_mode_reg      <= pwdata[0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= pwdata[COORD_W-1:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BPP_MODE:      prdata = {{(CFG_DATA_W-1){1'b0}}, bpp_mode_reg};
            REG_SPRITE_WIDTH:  prdata = {{(CFG_DATA_W-COORD_W){1'b0}}, sprite_width_reg};
            REG_SPRITE_HEIGHT: prdata = {{(CFG_DATA_W-COORD_W){1'b0}}, sprite_height_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic             p_valid_reg;
    logic [PIX_W-1:0] p_byte_reg;
    logic             m_tvalid_reg;
    logic             out_free;
    logic             row_done;
    logic             p_advance;
    logic             s_take;

    // The held byte moves on when it either completes no row or the result
    // register can take its result this cycle.
    assign out_free  = !m_tvalid_reg || m_tready;
    assign p_advance = p_valid_reg && (!row_done || out_free);
    assign s_tready  = !p_valid_reg || p_advance;
    assign s_take    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_take) begin
            p_valid_reg <= 1'b1;
        end else if (p_advance) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            p_byte_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Pixel evaluation for the held byte
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] column_pos_reg, column_pos_next;
    logic [COORD_W-1:0] running_min_reg, running_min_next;
    logic [COORD_W-1:0] running_max_reg, running_max_next;
    logic [COORD_W-1:0] row_count_reg, row_count_next;

    logic [3:0]         lane_val [LANES];
    logic [COORD_W:0]   lane_col [LANES];
    logic [LANES-1:0]   lane_hit;
    logic [COORD_W:0]   first_col;
    logic [COORD_W:0]   last_end;
    logic               any_hit;
    logic [COORD_W-1:0] min_upd;
    logic [COORD_W-1:0] max_upd;
    logic [COORD_W:0]   pos_sum;
    logic               last_row;
    logic [COORD_W:0]   row_plus_one;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (bpp_mode_reg == BPP_4) begin
                // Two nibbles, the low one leftmost.
                if (k < 2) begin
                    lane_val[k] = p_byte_reg[(k & 1)*4 +: 4] & NIBBLE_MASK;
                end else begin
                    lane_val[k] = 4'h0;
                end
            end else begin
                // Four pairs, the most significant one leftmost.
                lane_val[k] = {2'b00, p_byte_reg[(3-k)*2 +: 2] & PAIR_MASK};
            end
            lane_col[k] = {1'b0, column_pos_reg} + (COORD_W+1)'(k);
            lane_hit[k] = (lane_val[k] != 4'h0) && (lane_col[k] < {1'b0, sprite_width_reg});
        end
    end

    always_comb begin
        first_col = '0;
        last_end  = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (lane_hit[k]) begin
                first_col = lane_col[k];
            end
        end
        for (int k = 0; k < LANES; k++) begin
            if (lane_hit[k]) begin
                last_end = lane_col[k] + (COORD_W+1)'(1);
            end
        end
    end

    assign any_hit = |lane_hit;

    // The first nonzero pixel of a row always loads the minimum.
    assign min_upd = (any_hit && ((running_max_reg == '0) ||
                      (first_col < {1'b0, running_min_reg}))) ?
                     first_col[COORD_W-1:0] : running_min_reg;
    assign max_upd = (any_hit && (last_end > {1'b0, running_max_reg})) ?
                     last_end[COORD_W-1:0] : running_max_reg;

    assign pos_sum  = {1'b0, column_pos_reg} +
                      ((bpp_mode_reg == BPP_4) ? (COORD_W+1)'(2) : (COORD_W+1)'(4));
    assign row_done = (pos_sum >= {1'b0, sprite_width_reg});

    assign row_plus_one = {1'b0, row_count_reg} + (COORD_W+1)'(1);
    assign last_row     = (row_plus_one >= {1'b0, sprite_height_reg});

    always_comb begin
        column_pos_next  = column_pos_reg;
        running_min_next = running_min_reg;
        running_max_next = running_max_reg;
        row_count_next   = row_count_reg;
        if (p_advance) begin
            if (row_done) begin
                column_pos_next  = '0;
                running_min_next = sprite_width_reg;
                running_max_next = '0;
                row_count_next   = last_row ? '0 : row_plus_one[COORD_W-1:0];
            end else begin
                column_pos_next  = pos_sum[COORD_W-1:0];
                running_min_next = min_upd;
                running_max_next = max_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_pos_reg  <= '0;
            running_min_reg <= WIDTH_RESET;
            running_max_reg <= '0;
            row_count_reg   <= '0;
        end else begin
            column_pos_reg  <= column_pos_next;
            running_min_reg <= running_min_next;
            running_max_reg <= running_max_next;
            row_count_reg   <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  emit;

    assign emit = p_advance && row_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // An empty row reports a span of zero to zero.
    always_ff @(posedge aclk) begin
        if (emit) begin
            if (max_upd == '0) begin
                m_tdata_reg <= {{(2*COORD_W){1'b0}}, row_count_reg};
            end else begin
                m_tdata_reg <= {max_upd, min_upd, row_count_reg};
            end
            m_tlast_reg <= last_row;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // A reported span is never empty or reversed unless it is zero to zero.
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[23:16] != 8'd0)) |-> (m_tdata[15:8] < m_tdata[23:16]))
        else $error("span start not below span end");

    a_empty_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[23:16] == 8'd0)) |-> (m_tdata[15:8] == 8'd0))
        else $error("empty row reported with nonzero start");

    // The input side stalls only when both registers are occupied and the result is not being taken.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (p_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A finished row always wraps the column position and clears the running maximum.
    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (column_pos_reg == '0) && (running_max_reg == '0))
        else $error("row state not cleared after a completed row");
`endif

endmodule
